// ===== rtl/core/mmg_pkg.sv =====
// Shared constants and types for the min-max gray rescale block.
package mmg_pkg;

  // Pixel word width and the widths that follow from it
  localparam int unsigned PixelBits = 16;
  localparam int unsigned InDataW   = ((PixelBits + 7) / 8) * 8;
  localparam int unsigned DiffW     = PixelBits + 1;   // signed difference
  localparam int unsigned NumW      = PixelBits + 9;   // 510*d + range
  localparam int unsigned DenW      = PixelBits + 1;   // 2*range
  localparam int unsigned GrayW     = 8;
  localparam int unsigned OutDataW  = ((GrayW + 7) / 8) * 8;
  localparam int unsigned InUserW   = 2;
  localparam int unsigned OutUserW  = 1;

  // Divider: one quotient bit per cycle
  localparam int unsigned QuoSteps  = GrayW;
  localparam int unsigned CntW      = $clog2(QuoSteps);
  localparam int unsigned ShDenW    = DenW + QuoSteps - 1;

  localparam logic [GrayW-1:0] GrayMax = {GrayW{1'b1}};

  // Opcode carried in tuser bit 0
  localparam logic OpMeasure = 1'b0;
  localparam logic OpScale   = 1'b1;

  // Divider request
  typedef struct packed {
    logic            start;
    logic [NumW-1:0] num;
    logic [DenW-1:0] den;
  } div_req_t;

endpackage

// ===== rtl/core/mmg_div.sv =====
// Bit-serial restoring divider giving an 8-bit quotient, one bit per cycle.
module mmg_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mmg_pkg::div_req_t req_i,
  output logic              done_o,
  output logic [mmg_pkg::GrayW-1:0] quo_o
);

  logic [mmg_pkg::NumW-1:0]   rem_q, rem_d;
  logic [mmg_pkg::ShDenW-1:0] dsr_q, dsr_d;
  logic [mmg_pkg::GrayW-1:0]  quo_q, quo_d;
  logic [mmg_pkg::CntW-1:0]   cnt_q, cnt_d;
  logic                       busy_q, busy_d;
  logic                       done_q, done_d;
  logic [mmg_pkg::NumW-1:0]   dsr_ext;
  logic                       fits;

  // Trial subtract of the shifted divisor
  assign dsr_ext = {{(mmg_pkg::NumW - mmg_pkg::ShDenW){1'b0}}, dsr_q};
  assign fits    = (rem_q >= dsr_ext);

  always_comb begin
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      rem_d  = req_i.num;
      dsr_d  = {req_i.den, {(mmg_pkg::QuoSteps - 1){1'b0}}};
      cnt_d  = mmg_pkg::CntW'(mmg_pkg::QuoSteps - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (fits) begin
        rem_d = rem_q - dsr_ext;
      end
      quo_d = {quo_q[mmg_pkg::GrayW-2:0], fits};
      dsr_d = dsr_q >> 1;
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  // Datapath shift registers
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dsr_q <= dsr_d;
    quo_q <= quo_d;
    cnt_q <= cnt_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// ===== rtl/core/minmax_gray_rescale_top.sv =====
// A measure transfer updates min/max and the block stays idle. A scale transfer
// passes through prep, load and, unless saturated or flat, the 8-step bit-serial
// divider, then done. Input is taken only while idle, so a scale item holds off new
// items until its result is loaded; measure items are taken every cycle while idle.
// Reset (async, active low): min reset to the largest pixel, max to the
// smallest, controller idle, no result pending.
module minmax_gray_rescale_top (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid_i,
  output logic s_axis_tready_o,
  input  logic [mmg_pkg::InDataW-1:0]  s_axis_tdata_i,  // [15:0] pixel
  input  logic [mmg_pkg::InUserW-1:0]  s_axis_tuser_i,  // [0] opcode, [1] frame_start
  output logic m_axis_tvalid_o,
  input  logic m_axis_tready_i,
  output logic [mmg_pkg::OutDataW-1:0] m_axis_tdata_o,  // [7:0] gray
  output logic [mmg_pkg::OutUserW-1:0] m_axis_tuser_o   // [0] flat_frame
);

  typedef enum logic [4:0] {
    StIdle = 5'b00001,
    StPrep = 5'b00010,
    StLoad = 5'b00100,
    StDiv  = 5'b01000,
    StDone = 5'b10000
  } state_e;

  localparam int unsigned P = mmg_pkg::PixelBits;

  state_e state_q, state_d;

  logic signed [P-1:0] min_q, min_d, max_q, max_d;
  logic signed [P-1:0] pix_q, pix_in;
  logic signed [mmg_pkg::DiffW-1:0] range_q, diff_q;
  logic [mmg_pkg::GrayW-1:0] res_gray_q, res_gray_d;
  logic res_flat_q, res_flat_d;
  logic out_valid_q, out_valid_d;
  logic [mmg_pkg::GrayW-1:0] out_gray_q;
  logic out_flat_q;
  logic in_xfer, out_load;
  logic range_le0, diff_le0, diff_ge;
  logic [mmg_pkg::NumW-1:0] d_ext, r_ext;
  mmg_pkg::div_req_t div_req;
  logic div_done;
  logic [mmg_pkg::GrayW-1:0] div_quo;

  assign s_axis_tready_o = (state_q == StIdle);
  assign in_xfer = s_axis_tvalid_i & s_axis_tready_o;
  assign pix_in  = signed'(s_axis_tdata_i[P-1:0]);

  // Case checks on the registered differences
  assign range_le0 = range_q[P] | (range_q == '0);
  assign diff_le0  = diff_q[P] | (diff_q == '0);
  assign diff_ge   = (diff_q >= range_q);

  // Numerator 510*d + range by shifts, denominator 2*range
  assign d_ext = {{(mmg_pkg::NumW - P){1'b0}}, diff_q[P-1:0]};
  assign r_ext = {{(mmg_pkg::NumW - P){1'b0}}, range_q[P-1:0]};
  assign div_req.start = (state_q == StLoad) & ~range_le0 & ~diff_le0 & ~diff_ge;
  assign div_req.num   = (d_ext << 9) - (d_ext << 1) + r_ext;
  assign div_req.den   = {range_q[P-1:0], 1'b0};

  mmg_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  assign out_load = (state_q == StDone) & (~out_valid_q | m_axis_tready_i);

  // Sequencer and running min/max
  always_comb begin
    state_d    = state_q;
    min_d      = min_q;
    max_d      = max_q;
    res_gray_d = res_gray_q;
    res_flat_d = res_flat_q;
    unique case (state_q)
      StIdle: begin
        if (in_xfer) begin
          if (s_axis_tuser_i[0] == mmg_pkg::OpMeasure) begin
            if (s_axis_tuser_i[1]) begin
              min_d = pix_in;
              max_d = pix_in;
            end else begin
              if (pix_in < min_q) min_d = pix_in;
              if (pix_in > max_q) max_d = pix_in;
            end
          end else begin
            state_d = StPrep;
          end
        end
      end
      StPrep: begin
        state_d = StLoad;
      end
      StLoad: begin
        res_flat_d = range_le0;
        if (range_le0 || diff_le0) begin
          res_gray_d = '0;
          state_d    = StDone;
        end else if (diff_ge) begin
          res_gray_d = mmg_pkg::GrayMax;
          state_d    = StDone;
        end else begin
          state_d = StDiv;
        end
      end
      StDiv: begin
        if (div_done) begin
          res_gray_d = div_quo;
          state_d    = StDone;
        end
      end
      StDone: begin
        if (out_load) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  // Output register holds the result until its transfer
  assign out_valid_d = (out_valid_q & ~m_axis_tready_i) | out_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      min_q       <= {1'b0, {(P-1){1'b1}}};
      max_q       <= {1'b1, {(P-1){1'b0}}};
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      min_q       <= min_d;
      max_q       <= max_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) pix_q <= pix_in;
    if (state_q == StPrep) begin
      range_q <= {max_q[P-1], max_q} - {min_q[P-1], min_q};
      diff_q  <= {pix_q[P-1], pix_q} - {min_q[P-1], min_q};
    end
    res_gray_q <= res_gray_d;
    res_flat_q <= res_flat_d;
    if (out_load) begin
      out_gray_q <= res_gray_q;
      out_flat_q <= res_flat_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(mmg_pkg::OutDataW - mmg_pkg::GrayW){1'b0}}, out_gray_q};
  assign m_axis_tuser_o  = out_flat_q;

endmodule
